>>> rtl/obmc_pkg.sv
package obmc_pkg;

  // half-pel interpolation modes: bit0 horizontal half, bit1 vertical half
  typedef enum logic [1:0] {
    MODE_COPY    = 2'd0,
    MODE_HALF_H  = 2'd1,
    MODE_HALF_V  = 2'd2,
    MODE_HALF_HV = 2'd3
  } mode_e;

  localparam int unsigned SampleW = 8;
  localparam int unsigned PosW    = 3;
  localparam int unsigned SumW    = 11;  // 255 * 8 + 4 fits in 11 bits

  // one input beat, held in the input register
  typedef struct packed {
    logic [PosW-1:0]      row;
    logic [PosW-1:0]      col;
    logic [4*SampleW-1:0] cur_samples;
    logic [1:0]           cur_mode;
    logic [4*SampleW-1:0] vert_samples;
    logic [1:0]           vert_mode;
    logic [4*SampleW-1:0] horz_samples;
    logic [1:0]           horz_mode;
  } item_t;

  // position weights, indexed by {row, col}; each position sums to 8
  localparam logic [2:0] WCUR [64] = '{
    3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
    3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4
  };

  localparam logic [1:0] WVERT [64] = '{
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1,
    2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2
  };

  localparam logic [1:0] WHORZ [64] = '{
    2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2,
    2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2,
    2'd2, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2,
    2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2
  };

endpackage

>>> rtl/obmc_half_pel_blend_top.sv
// Overlapped block motion compensation blender for half-pel luma: each input beat
// carries one pixel position of an 8x8 block and three 2x2 reference
// neighbourhoods (current, vertical neighbour and horizontal neighbour vectors),
// each with its own half-pel mode; the block interpolates the three predictions
// and blends them with the standard position weights, giving one output beat per
// input beat with row and column echoed. Throughput is one pixel per clock
// while out_stall_i does not hold the output; each beat is registered first in
// the input register and then in the result register, with the
// interpolate-and-blend logic between them.
// rounding_type is written through cfg_we_i/cfg_wdata_i and resets to 0; the user
// must write it only while no beat is in flight, which the block does not enforce.
module obmc_half_pel_blend_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  // input channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [obmc_pkg::PosW-1:0]      row_i,
  input  logic [obmc_pkg::PosW-1:0]      col_i,
  input  logic [4*obmc_pkg::SampleW-1:0] cur_samples_i,
  input  logic [1:0]                     cur_mode_i,
  input  logic [4*obmc_pkg::SampleW-1:0] vert_samples_i,
  input  logic [1:0]                     vert_mode_i,
  input  logic [4*obmc_pkg::SampleW-1:0] horz_samples_i,
  input  logic [1:0]                     horz_mode_i,
  // output channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [obmc_pkg::SampleW-1:0]   pixel_out_o,
  output logic [obmc_pkg::PosW-1:0]      row_out_o,
  output logic [obmc_pkg::PosW-1:0]      col_out_o
);
  import obmc_pkg::*;

  logic               rounding_type_q;
  item_t              item_q;
  logic               item_valid_q;
  logic               out_valid_q;
  logic [SampleW-1:0] pixel_d, pixel_q;
  logic [PosW-1:0]    row_q, col_q;
  logic               out_free;
  logic               advance;
  logic               in_accept;

  // rounding control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rounding_type_q <= 1'b0;
    end else if (cfg_we_i) begin
      rounding_type_q <= cfg_wdata_i;
    end
  end

  // pipeline flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.row          <= row_i;
      item_q.col          <= col_i;
      item_q.cur_samples  <= cur_samples_i;
      item_q.cur_mode     <= cur_mode_i;
      item_q.vert_samples <= vert_samples_i;
      item_q.vert_mode    <= vert_mode_i;
      item_q.horz_samples <= horz_samples_i;
      item_q.horz_mode    <= horz_mode_i;
    end
  end

  // interpolation and weighted blend
  obmc_blend u_blend (
    .item_i          (item_q),
    .rounding_type_i (rounding_type_q),
    .pixel_o         (pixel_d)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= item_valid_q;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      pixel_q <= pixel_d;
      row_q   <= item_q.row;
      col_q   <= item_q.col;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;
  assign row_out_o   = row_q;
  assign col_out_o   = col_q;

`ifndef SYNTH
  // a beat leaving the input register shows up at the output next cycle
  a_advance_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("beat advanced but output not valid");

  // the input side only stalls while a beat is held in the input register
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> item_valid_q)
    else $error("input stalled with empty input register");

  // a taken output with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !item_valid_q) |=> !out_valid_o)
    else $error("output beat repeated");

  // position travels with the beat
  a_pos_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (row_out_o == $past(item_q.row)) && (col_out_o == $past(item_q.col)))
    else $error("row or column not carried with beat");
`endif

endmodule

>>> rtl/obmc_interp.sv
module obmc_interp (
  input  logic [4*obmc_pkg::SampleW-1:0] samples_i,
  input  logic [1:0]                     mode_i,
  input  logic                           rounding_type_i,
  output logic [obmc_pkg::SampleW-1:0]   pred_o
);
  import obmc_pkg::*;

  logic [SampleW-1:0] a, b, c, d;
  logic [SampleW:0]   sum_h;
  logic [SampleW:0]   sum_v;
  logic [SampleW+1:0] sum_hv;

  // unpack the 2x2 neighbourhood
  assign a = samples_i[SampleW-1:0];
  assign b = samples_i[2*SampleW-1:SampleW];
  assign c = samples_i[3*SampleW-1:2*SampleW];
  assign d = samples_i[4*SampleW-1:3*SampleW];

  // two-tap offset is 1 - rnd, four-tap offset is 2 - rnd
  assign sum_h  = {1'b0, a} + {1'b0, b} + {{SampleW{1'b0}}, ~rounding_type_i};
  assign sum_v  = {1'b0, a} + {1'b0, c} + {{SampleW{1'b0}}, ~rounding_type_i};
  assign sum_hv = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d}
                + (SampleW+2)'({~rounding_type_i, rounding_type_i});

  // select the prediction by half-pel mode
  always_comb begin
    case (mode_e'(mode_i))
      MODE_COPY:    pred_o = a;
      MODE_HALF_H:  pred_o = sum_h[SampleW:1];
      MODE_HALF_V:  pred_o = sum_v[SampleW:1];
      MODE_HALF_HV: pred_o = sum_hv[SampleW+1:2];
      default:      pred_o = a;
    endcase
  end

endmodule

>>> rtl/obmc_blend.sv
module obmc_blend (
  input  obmc_pkg::item_t              item_i,
  input  logic                         rounding_type_i,
  output logic [obmc_pkg::SampleW-1:0] pixel_o
);
  import obmc_pkg::*;

  logic [SampleW-1:0] pred_cur, pred_vert, pred_horz;
  logic [5:0]         pos;
  logic [2:0]         w_cur;
  logic [1:0]         w_vert, w_horz;
  logic [SumW-1:0]    prod_cur, prod_vert, prod_horz;
  logic [SumW-1:0]    sum;

  // three half-pel predictions
  obmc_interp u_interp_cur (
    .samples_i       (item_i.cur_samples),
    .mode_i          (item_i.cur_mode),
    .rounding_type_i (rounding_type_i),
    .pred_o          (pred_cur)
  );

  obmc_interp u_interp_vert (
    .samples_i       (item_i.vert_samples),
    .mode_i          (item_i.vert_mode),
    .rounding_type_i (rounding_type_i),
    .pred_o          (pred_vert)
  );

  obmc_interp u_interp_horz (
    .samples_i       (item_i.horz_samples),
    .mode_i          (item_i.horz_mode),
    .rounding_type_i (rounding_type_i),
    .pred_o          (pred_horz)
  );

  // position weight lookup
  assign pos    = {item_i.row, item_i.col};
  assign w_cur  = WCUR[pos];
  assign w_vert = WVERT[pos];
  assign w_horz = WHORZ[pos];

  // weighted sum, round and divide by 8; weights sum to 8 so no clipping
  assign prod_cur  = SumW'(pred_cur)  * SumW'(w_cur);
  assign prod_vert = SumW'(pred_vert) * SumW'(w_vert);
  assign prod_horz = SumW'(pred_horz) * SumW'(w_horz);
  assign sum       = prod_cur + prod_vert + prod_horz + SumW'(4);
  assign pixel_o   = sum[SumW-1:3];

endmodule
